### src/pip_pkg.sv
`timescale 1ns / 1ps
package pip_pkg;

    // Per-job control carried from the front end to the back end
    typedef struct packed {
        logic has_prev;   // a polygon was already open: the edge to the previous vertex counts
        logic last;       // closing vertex: test the closing edge and give a result
    } t_job_flags;

    localparam int JOB_FLAG_BITS = $bits(t_job_flags);

    // Job queue between front and back end, and result queue at the output
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

endpackage

### src/pip_fifo.sv
`timescale 1ns / 1ps
module pip_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [WIDTH-1:0]           i_wr_data,
    input  logic                       i_rd,
    output logic [WIDTH-1:0]           o_rd_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH):0]     o_count
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count + CW'(wr_en) - CW'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_count   = r_count;

    // Pointer distance must always agree with the occupancy count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[AW-1:0])
        else $error("fifo pointers disagree with count");

endmodule

### src/pip_front.sv
`timescale 1ns / 1ps
module pip_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic signed [COORD_BITS-1:0]  i_vertex_x,
    input  logic signed [COORD_BITS-1:0]  i_vertex_y,
    input  logic signed [COORD_BITS-1:0]  i_query_x,
    input  logic signed [COORD_BITS-1:0]  i_query_y,
    input  logic                          i_last_vertex,
    output logic [8*COORD_BITS+pip_pkg::JOB_FLAG_BITS-1:0] o_job
);
    import pip_pkg::*;

    localparam int CB = COORD_BITS;

    logic                 r_started;
    logic signed [CB-1:0] r_first_x, r_first_y;
    logic signed [CB-1:0] r_prev_x, r_prev_y;
    logic signed [CB-1:0] r_qx, r_qy;

    logic signed [CB-1:0] first_x, first_y, qx, qy;
    t_job_flags           flags;

    // Classify: a new polygon takes its query point and first vertex from this word
    always_comb begin
        first_x        = r_started ? r_first_x : i_vertex_x;
        first_y        = r_started ? r_first_y : i_vertex_y;
        qx             = r_started ? r_qx : i_query_x;
        qy             = r_started ? r_qy : i_query_y;
        flags.has_prev = r_started;
        flags.last     = i_last_vertex;
    end

    assign o_job = {flags, qy, qx, first_y, first_x, r_prev_y, r_prev_x,
                    i_vertex_y, i_vertex_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else if (i_accept) begin
            r_started <= !i_last_vertex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_prev_x <= i_vertex_x;
            r_prev_y <= i_vertex_y;
            if (!r_started) begin
                r_first_x <= i_vertex_x;
                r_first_y <= i_vertex_y;
                r_qx      <= i_query_x;
                r_qy      <= i_query_y;
            end
        end
    end

endmodule

### src/pip_back.sv
`timescale 1ns / 1ps
module pip_back #(
    parameter int COORD_BITS = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_job_empty,
    input  logic [8*COORD_BITS+pip_pkg::JOB_FLAG_BITS-1:0] i_job,
    output logic                                           o_job_pop,
    output logic                                           o_res_empty,
    input  logic                                           i_res_pop,
    output logic                                           o_inside_res
);
    import pip_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2 * DW;
    localparam int OCW = $clog2(OUT_DEPTH) + 1;

    // Unpack the job word: edge 0 runs to the previous vertex, edge 1 to the first
    logic signed [CB-1:0] cur_x, cur_y, qx, qy;
    logic signed [CB-1:0] end_x [2];
    logic signed [CB-1:0] end_y [2];
    t_job_flags           job_flags;

    assign cur_x     = $signed(i_job[0*CB +: CB]);
    assign cur_y     = $signed(i_job[1*CB +: CB]);
    assign end_x[0]  = $signed(i_job[2*CB +: CB]);
    assign end_y[0]  = $signed(i_job[3*CB +: CB]);
    assign end_x[1]  = $signed(i_job[4*CB +: CB]);
    assign end_y[1]  = $signed(i_job[5*CB +: CB]);
    assign qx        = $signed(i_job[6*CB +: CB]);
    assign qy        = $signed(i_job[7*CB +: CB]);
    assign job_flags = t_job_flags'(i_job[8*CB +: JOB_FLAG_BITS]);

    // Stage 1: differences and straddle test
    logic                 r_v1;
    t_job_flags           r_flags1;
    logic                 r_str1   [2];
    logic                 r_dypos1 [2];
    logic signed [DW-1:0] r_dy1    [2];
    logic signed [DW-1:0] r_qxa1   [2];
    logic signed [DW-1:0] r_bxa1   [2];
    logic signed [DW-1:0] r_qya1   [2];

    // Stage 2: cross products
    logic                 r_v2;
    t_job_flags           r_flags2;
    logic                 r_str2   [2];
    logic                 r_dypos2 [2];
    logic signed [PW-1:0] r_lhs2   [2];
    logic signed [PW-1:0] r_rhs2   [2];

    logic                 r_parity;
    logic                 crossed [2];
    logic                 n_parity;

    logic                 res_full;
    logic [OCW-1:0]       res_count;
    logic [OCW-1:0]       credit_used;
    logic                 res_wr;

    // Reserve a result slot for every closing vertex still in the pipe
    assign credit_used = res_count + OCW'(r_v1 && r_flags1.last)
                                   + OCW'(r_v2 && r_flags2.last);
    assign o_job_pop   = !i_job_empty && (credit_used < OCW'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= o_job_pop;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags1 <= job_flags;
        for (int e = 0; e < 2; e++) begin
            r_str1[e]   <= (cur_y > qy) != (end_y[e] > qy);
            r_dypos1[e] <= end_y[e] > cur_y;
            r_dy1[e]    <= DW'(end_y[e]) - DW'(cur_y);
            r_qxa1[e]   <= DW'(qx) - DW'(cur_x);
            r_bxa1[e]   <= DW'(end_x[e]) - DW'(cur_x);
            r_qya1[e]   <= DW'(qy) - DW'(cur_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_flags2 <= r_flags1;
        for (int e = 0; e < 2; e++) begin
            r_str2[e]   <= r_str1[e];
            r_dypos2[e] <= r_dypos1[e];
            r_lhs2[e]   <= PW'(r_qxa1[e]) * PW'(r_dy1[e]);
            r_rhs2[e]   <= PW'(r_bxa1[e]) * PW'(r_qya1[e]);
        end
    end

    // Compare with the direction set by the sign of the edge's y span
    always_comb begin
        for (int e = 0; e < 2; e++) begin
            crossed[e] = r_str2[e] && (r_dypos2[e] ? (r_lhs2[e] < r_rhs2[e])
                                                   : (r_rhs2[e] < r_lhs2[e]));
        end
        n_parity = (r_flags2.has_prev ? r_parity : 1'b0)
                 ^ (r_flags2.has_prev && crossed[0])
                 ^ (r_flags2.last && crossed[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (r_v2) begin
            r_parity <= n_parity;
        end
    end

    assign res_wr = r_v2 && r_flags2.last;

    pip_fifo #(
        .WIDTH (1),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (res_wr),
        .i_wr_data (n_parity),
        .i_rd      (i_res_pop),
        .o_rd_data (o_inside_res),
        .o_full    (res_full),
        .o_empty   (o_res_empty),
        .o_count   (res_count)
    );

    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !res_full)
        else $error("result written while result queue full");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        credit_used <= OCW'(OUT_DEPTH))
        else $error("result credit exceeded");

    a_issue_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_v1 && (r_flags1.last == $past(job_flags.last))))
        else $error("popped job lost on entry to pipeline");

endmodule

### src/point_in_polygon_crossing_test.sv
`timescale 1ns / 1ps
// Even-odd point-in-polygon test over a stream of vertex words. The first word of a
// polygon also carries the query point, which is held until the polygon closes; query
// fields of later words are ignored. Each word after the first tests the edge back to
// the previous vertex, and a word with last_vertex set also tests the closing edge to
// the first vertex and yields one inside/outside result (1 = inside). Crossings are
// decided exactly by cross-multiplication, with no rounding. One vertex word is taken
// every clock while the job queue has room; a new word enters while earlier ones are
// still in the arithmetic pipe. With both queues otherwise empty, a closing word goes
// out of the job queue into the difference stage, then into the multiplier stage and
// then into the result queue, where its result is visible on the result port.
// A four-entry job queue sits between the front end and the arithmetic, and a
// four-entry result queue at the output, so either side may stall without the other
// losing a word; the arithmetic only issues a job while a result slot is reserved.
module point_in_polygon_crossing_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_BITS-1:0]  i_vertex_x,
    input  logic signed [COORD_BITS-1:0]  i_vertex_y,
    input  logic signed [COORD_BITS-1:0]  i_query_x,
    input  logic signed [COORD_BITS-1:0]  i_query_y,
    input  logic                          i_last_vertex,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_inside_res
);
    import pip_pkg::*;

    localparam int JW = 8 * COORD_BITS + JOB_FLAG_BITS;
    localparam int MCW = $clog2(MID_DEPTH) + 1;

    logic          accept;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;
    logic          job_empty;
    logic          job_pop;
    logic [MCW-1:0] job_count;

    // Accept a word whenever the job queue has room
    assign accept = push && !full;

    // Front end: track the open polygon and form the job for this word
    pip_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_vertex_x    (i_vertex_x),
        .i_vertex_y    (i_vertex_y),
        .i_query_x     (i_query_x),
        .i_query_y     (i_query_y),
        .i_last_vertex (i_last_vertex),
        .o_job         (job_in)
    );

    // Job queue: decouple word acceptance from the arithmetic pipe
    pip_fifo #(
        .WIDTH (JW),
        .DEPTH (MID_DEPTH)
    ) u_job_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_data (job_in),
        .i_rd      (job_pop),
        .o_rd_data (job_out),
        .o_full    (full),
        .o_empty   (job_empty),
        .o_count   (job_count)
    );

    // Back end: crossing tests, parity and result queue
    pip_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (job_empty),
        .i_job        (job_out),
        .o_job_pop    (job_pop),
        .o_res_empty  (empty),
        .i_res_pop    (pop),
        .o_inside_res (o_inside_res)
    );

    // Hold the job queue occupancy within its depth
    a_job_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_count <= MCW'(MID_DEPTH))
        else $error("job queue count out of range");

endmodule
